@@ hdl/psff_pkg.sv @@
// ----------------------------------------------------------------------------
// psff_pkg - shared definitions for the pedal sensor filter and fault block
// Constants, register indexes, fault codes and the sequencer state type.
// ----------------------------------------------------------------------------
package psff_pkg;

  // default converter width
  localparam int SAMPLE_BITS_DEF = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int ALPHA_BITS = 17;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd4;

  // register reset values (sample-level ones are cut to SAMPLE_BITS)
  localparam logic [15:0]           LOW_LIMIT_RST  = 16'd100;
  localparam logic [15:0]           HIGH_LIMIT_RST = 16'd3995;
  localparam logic [15:0]           IDLE_LEVEL_RST = 16'd500;
  localparam logic [15:0]           FULL_LEVEL_RST = 16'd3500;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RST      = 17'd6554;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE      = 17'h10000;

  // result
  localparam int PERCENT_BITS = 15;
  localparam logic [PERCENT_BITS-1:0] PERCENT_FULL = 15'd25600;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_WIRE  = 2'd1;
  localparam logic [1:0] FAULT_SHORT = 2'd2;

  // sequencer
  localparam int CNT_W     = 4;
  localparam int MUL_STEPS = 9;   // radix-4 digits of the 18-bit padded alpha
  localparam int DIV_STEPS = 15;  // quotient bits

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_MUL,
    ST_UPDATE,
    ST_MAGS,
    ST_NUMER,
    ST_DSAT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ hdl/pedal_sensor_filter_and_fault_top.sv @@
// ----------------------------------------------------------------------------
// pedal_sensor_filter_and_fault_top - pedal sample filter with range check
// Range fault check, exponential average and percent mapping, digit serial.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw converter sample per transfer (valid/ready).
//   out_* : one result per sample: percent (Q7.8), fault code and the filter
//           state in Q12.16 (valid/ready, held in an output register).
//   cfg_* : register write port, one write per cycle at cfg_we. Unknown indexes
//           are dropped. User writes only while the block is idle (not enforced).
// Processing:
//   A good sample passes through fault check, operand setup, 9 radix-4
//   multiplier steps, state update, magnitude and numerator prep, a
//   saturation test, 15 restoring divider steps and the DONE hand-off. A
//   zero percent skips the divider, a clamped one leaves after the test, a
//   faulted sample goes from the fault check straight to DONE.
//   One sample is in flight at a time; in_ready returns once the result is
//   loaded into the output register. The multiplier digit loop and the
//   divider bit loop take most of a sample's time.
// Reset: registers go to their defaults, filter state to zero, no result.
// Stall: a finished result waits in the output register; the next sample is
//   taken meanwhile and its result waits in DONE until the slot frees up.
// ----------------------------------------------------------------------------
module pedal_sensor_filter_and_fault_top #(
  parameter int SAMPLE_BITS = psff_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psff_pkg::PERCENT_BITS-1:0]   out_percent,
  output logic [1:0]                          out_fault,
  output logic [SAMPLE_BITS+15:0]             out_smoothed_level,
  // configuration
  input  logic                                cfg_we,
  input  logic [psff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [((SAMPLE_BITS > psff_pkg::ALPHA_BITS) ?
                 SAMPLE_BITS : psff_pkg::ALPHA_BITS)-1:0] cfg_wdata
);
  import psff_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int LB  = SB + 16;        // filter state, Q.16
  localparam int DW  = LB + 1;         // signed sample-minus-state
  localparam int D3W = LB + 3;         // signed 3x difference
  localparam int PW  = LB + 19;        // signed product accumulator
  localparam int NW  = LB + 8;         // divide numerator
  localparam int RW  = SB + 8;         // remainder / divisor
  localparam int AW  = 18;             // alpha padded to whole radix-4 digits

  // ---------------- configuration registers ----------------
  logic [SB-1:0]         low_r, high_r, idle_r, full_r;
  logic [ALPHA_BITS-1:0] alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= LOW_LIMIT_RST[SB-1:0];
      high_r  <= HIGH_LIMIT_RST[SB-1:0];
      idle_r  <= IDLE_LEVEL_RST[SB-1:0];
      full_r  <= FULL_LEVEL_RST[SB-1:0];
      alpha_r <= ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:  low_r   <= cfg_wdata[SB-1:0];
        REG_HIGH_LIMIT: high_r  <= cfg_wdata[SB-1:0];
        REG_IDLE_LEVEL: idle_r  <= cfg_wdata[SB-1:0];
        REG_FULL_LEVEL: full_r  <= cfg_wdata[SB-1:0];
        REG_ALPHA:      alpha_r <= cfg_wdata[ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer and datapath registers ----------------
  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SB-1:0]     sample_r, sample_nxt;
  logic [LB-1:0]     level_r, level_nxt;        // filter state
  logic signed [DW-1:0]  d_r, d_nxt;
  logic signed [D3W-1:0] d3_r, d3_nxt;
  logic [AW-1:0]     a_r, a_nxt;                // multiplier digit shifter
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic [LB-1:0]     dmag_r, dmag_nxt;
  logic [SB-1:0]     smag_r, smag_nxt;
  logic              zero_r, zero_nxt;          // percent forced to zero
  logic [NW-1:0]     num_r, num_nxt;            // numerator, shifts out MSB first
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] q_r, q_nxt;
  logic [PERCENT_BITS-1:0] pct_r, pct_nxt;
  logic [1:0]        fault_r, fault_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [PERCENT_BITS-1:0]   out_pct_r, out_pct_nxt;
  logic [1:0]                out_fault_r, out_fault_nxt;
  logic [LB-1:0]             out_lvl_r, out_lvl_nxt;

  logic in_xfer;
  logic out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // ---------------- combinational helpers ----------------
  logic fault_wire, fault_short;
  logic [ALPHA_BITS-1:0] alpha_sat;
  logic signed [PW-1:0]  pp;
  logic signed [PW-1:0]  rnd;
  logic signed [D3W-1:0] delta;
  logic [D3W-1:0]        lvl_sum;
  logic [LB-1:0]         idle_q;
  logic                  dneg, sneg;
  logic [SB+8:0]         top;      // numerator bits above the quotient field
  logic [SB+8:0]         den;      // divisor, one bit of headroom
  logic [SB+8:0]         trial;
  logic                  trial_ge;
  logic [DIV_STEPS-1:0]  q_full;

  assign fault_wire  = sample_r < low_r;
  assign fault_short = sample_r > high_r;
  assign alpha_sat   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  // radix-4 partial product
  always_comb begin
    case (a_r[AW-1:AW-2])
      2'd0:    pp = '0;
      2'd1:    pp = {{(PW-DW){d_r[DW-1]}}, d_r};
      2'd2:    pp = {{(PW-DW-1){d_r[DW-1]}}, d_r, 1'b0};
      2'd3:    pp = {{(PW-D3W){d3_r[D3W-1]}}, d3_r};
      default: pp = '0;
    endcase
  end

  // round half up, then drop the 16 fraction bits
  assign rnd     = acc_r + PW'(32768);
  assign delta   = D3W'(rnd >>> 16);
  assign lvl_sum = {3'b000, level_r} + delta;

  assign idle_q = {idle_r, 16'b0};
  assign dneg   = level_r < idle_q;
  assign sneg   = full_r < idle_r;

  assign top      = num_r[NW-1:DIV_STEPS];
  assign den      = {1'b0, smag_r, 8'b0};
  assign trial    = {rem_r, num_r[DIV_STEPS-1]};
  assign trial_ge = trial >= den;
  assign q_full   = {q_r[DIV_STEPS-2:0], trial_ge};

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = (fault_wire || fault_short) ? ST_DONE : ST_SETUP;
      ST_SETUP:  state_nxt = ST_MUL;
      ST_MUL:    if (cnt_r == '0) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_MAGS;
      ST_MAGS:   state_nxt = ST_NUMER;
      ST_NUMER:  state_nxt = zero_r ? ST_DONE : ST_DSAT;
      ST_DSAT:   state_nxt = (top >= den) ? ST_DONE : ST_DIV;
      ST_DIV:    if (cnt_r == '0) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    cnt_nxt       = cnt_r;
    sample_nxt    = sample_r;
    level_nxt     = level_r;
    d_nxt         = d_r;
    d3_nxt        = d3_r;
    a_nxt         = a_r;
    acc_nxt       = acc_r;
    dmag_nxt      = dmag_r;
    smag_nxt      = smag_r;
    zero_nxt      = zero_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    pct_nxt       = pct_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pct_nxt   = out_pct_r;
    out_fault_nxt = out_fault_r;
    out_lvl_nxt   = out_lvl_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) sample_nxt = in_sample;
      end
      ST_CHECK: begin
        pct_nxt = '0;
        if (fault_wire)       fault_nxt = FAULT_WIRE;
        else if (fault_short) fault_nxt = FAULT_SHORT;
        else                  fault_nxt = FAULT_NONE;
      end
      ST_SETUP: begin
        d_nxt   = $signed({1'b0, sample_r, 16'b0}) - $signed({1'b0, level_r});
        d3_nxt  = {{(D3W-DW){d_nxt[DW-1]}}, d_nxt}
                + {{(D3W-DW-1){d_nxt[DW-1]}}, d_nxt, 1'b0};
        a_nxt   = {1'b0, alpha_sat};
        acc_nxt = '0;
        cnt_nxt = CNT_W'(MUL_STEPS - 1);
      end
      ST_MUL: begin
        acc_nxt = (acc_r <<< 2) + pp;
        a_nxt   = {a_r[AW-3:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
      end
      ST_UPDATE: begin
        level_nxt = lvl_sum[LB-1:0];
      end
      ST_MAGS: begin
        dmag_nxt = dneg ? (idle_q - level_r) : (level_r - idle_q);
        smag_nxt = sneg ? (idle_r - full_r) : (full_r - idle_r);
        zero_nxt = (idle_r == full_r) || (level_r == idle_q) || (dneg != sneg);
      end
      ST_NUMER: begin
        // dmag*100 + smag*128, divided later by smag*256
        num_nxt = ({8'b0, dmag_r} << 6) + ({8'b0, dmag_r} << 5)
                + ({8'b0, dmag_r} << 2) + {{(NW-SB-7){1'b0}}, smag_r, 7'b0};
        pct_nxt = '0;
      end
      ST_DSAT: begin
        pct_nxt = PERCENT_FULL;
        rem_nxt = top[RW-1:0];
        q_nxt   = '0;
        cnt_nxt = CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? RW'(trial - den) : trial[RW-1:0];
        q_nxt   = q_full;
        num_nxt = {num_r[NW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) pct_nxt = (q_full > PERCENT_FULL) ? PERCENT_FULL : q_full;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = pct_r;
          out_fault_nxt = fault_r;
          out_lvl_nxt   = level_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      level_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    sample_r    <= sample_nxt;
    d_r         <= d_nxt;
    d3_r        <= d3_nxt;
    a_r         <= a_nxt;
    acc_r       <= acc_nxt;
    dmag_r      <= dmag_nxt;
    smag_r      <= smag_nxt;
    zero_r      <= zero_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    pct_r       <= pct_nxt;
    fault_r     <= fault_nxt;
    out_pct_r   <= out_pct_nxt;
    out_fault_r <= out_fault_nxt;
    out_lvl_r   <= out_lvl_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_percent        = out_pct_r;
  assign out_fault          = out_fault_r;
  assign out_smoothed_level = out_lvl_r;

endmodule
